// File: hw/rtl/assert_macros.svh
// Assertion helpers for the PPM decoder. Each macro names its assertion and
// checks on the rising edge of aclk, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PPMD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppm decoder assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PPMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppm decoder assertion failed");
`else
`define PPMD_ASSERT_NOW(lbl, ante, cons)
`define PPMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/ppmd_pkg.sv
package ppmd_pkg;

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int WIDTH_W    = 16;
    localparam int PIN_W      = 8;
    localparam int SLOT_W     = 3;
    localparam int MODE_W     = 3;
    localparam int MODES_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_CHANNELS     = 8;
    localparam int CHANNELS_DEFAULT = 8;

    // Packed stream data widths.
    localparam int M_TDATA_W = 40;
    localparam int S_TDATA_W = 32;

    // Channel mode codes.
    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PWM        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWITCH     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INV_SWITCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SELECTOR   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THRESHOLD = 2'd2;

    // Register reset values.
    localparam logic [WIDTH_W-1:0] SYNC_GAP_RESET  = 16'd3000;
    localparam logic [WIDTH_W-1:0] THRESHOLD_RESET = 16'd1500;

    // One decoded result per edge.
    typedef struct packed {
        logic                frame_active;
        logic                width_valid;
        logic [WIDTH_W-1:0]  channel_width_us;
        logic [SLOT_W-1:0]   closed_channel;
        logic [PIN_W-1:0]    secondary_pins;
        logic [PIN_W-1:0]    primary_pins;
    } ppmd_result_t;

endpackage

// File: hw/rtl/ppmd_in_stage.sv
module ppmd_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ppmd_pkg::TIME_W-1:0]   s_tdata,
    input  logic                          down_ready,
    output logic                          item_valid,
    output logic                          item_advance,
    output logic [ppmd_pkg::TIME_W-1:0]   item_time
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [ppmd_pkg::TIME_W-1:0] in_time_reg;

    // The held edge moves on whenever the result register can take it.
    assign item_advance = in_valid_reg && down_ready;
    assign s_tready     = !in_valid_reg || down_ready;
    assign item_valid   = in_valid_reg;
    assign item_time    = in_time_reg;

    // Occupancy of the input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (item_advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Timestamp capture; no reset needed for payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg <= s_tdata;
        end
    end

endmodule

// File: hw/rtl/ppmd_core.sv
module ppmd_core #(
    parameter int CHANNELS = ppmd_pkg::CHANNELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppmd_pkg::MODES_W-1:0]      cfg_wdata,
    input  logic                              item_advance,
    input  logic [ppmd_pkg::TIME_W-1:0]       item_time,
    output ppmd_pkg::ppmd_result_t            result
);

    localparam int STORE_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [ppmd_pkg::SLOT_W-1:0] LAST_SLOT = ppmd_pkg::SLOT_W'(CHANNELS - 1);

    // Configuration registers.
    logic [ppmd_pkg::MODES_W-1:0] modes_reg, modes_next;
    logic [ppmd_pkg::WIDTH_W-1:0] sync_gap_reg, sync_gap_next;
    logic [ppmd_pkg::WIDTH_W-1:0] threshold_reg, threshold_next;

    // Decoder state.
    logic                          in_frame_reg, in_frame_next;
    logic                          edge_seen_reg, edge_seen_next;
    logic [ppmd_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [ppmd_pkg::TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic [ppmd_pkg::PIN_W-1:0]    primary_reg, primary_next;
    logic [ppmd_pkg::PIN_W-1:0]    secondary_reg, secondary_next;
    logic [ppmd_pkg::WIDTH_W-1:0]  width_store_reg [CHANNELS];
    logic [ppmd_pkg::WIDTH_W-1:0]  width_store_next [CHANNELS];

    // Per-edge working values.
    logic [ppmd_pkg::TIME_W-1:0]   gap;
    logic                          time_advanced;
    logic [ppmd_pkg::WIDTH_W-1:0]  sat_width;
    logic [ppmd_pkg::WIDTH_W-1:0]  closed_width;
    logic [STORE_IDX_W-1:0]        store_idx;
    logic [ppmd_pkg::SLOT_W-1:0]   next_slot;
    logic [ppmd_pkg::MODE_W-1:0]   cur_mode;
    logic [ppmd_pkg::MODE_W-1:0]   next_mode;
    logic [ppmd_pkg::MODE_W-1:0]   first_mode;
    logic [ppmd_pkg::MODE_W-1:0]   new_mode;
    logic                          above;
    logic                          below;

    // Slot width measurement, saturated to sixteen bits.
    always_comb begin
        gap           = item_time - prev_time_reg;
        time_advanced = item_time > prev_time_reg;
        sat_width     = (|gap[ppmd_pkg::TIME_W-1:ppmd_pkg::WIDTH_W]) ? '1
                                                                      : gap[ppmd_pkg::WIDTH_W-1:0];
        store_idx     = slot_reg[STORE_IDX_W-1:0];
        closed_width  = time_advanced ? sat_width : width_store_reg[store_idx];
        above         = closed_width > threshold_reg;
        below         = closed_width < threshold_reg;
        next_slot     = slot_reg + 1'b1;
        cur_mode      = modes_reg[ppmd_pkg::MODE_W*slot_reg +: ppmd_pkg::MODE_W];
        next_mode     = modes_reg[ppmd_pkg::MODE_W*next_slot +: ppmd_pkg::MODE_W];
        first_mode    = modes_reg[ppmd_pkg::MODE_W-1:0];
    end

    // Edge handling, then configuration writes.
    always_comb begin
        modes_next     = modes_reg;
        sync_gap_next  = sync_gap_reg;
        threshold_next = threshold_reg;
        in_frame_next  = in_frame_reg;
        edge_seen_next = edge_seen_reg;
        slot_next      = slot_reg;
        prev_time_next = prev_time_reg;
        primary_next   = primary_reg;
        secondary_next = secondary_reg;
        width_store_next = width_store_reg;
        new_mode       = ppmd_pkg::MODE_NONE;

        result                  = '0;

        if (item_advance) begin
            if (in_frame_reg) begin
                // The edge closes the current slot.
                if (time_advanced) begin
                    width_store_next[store_idx] = sat_width;
                end
                result.closed_channel   = slot_reg;
                result.channel_width_us = closed_width;
                result.width_valid      = 1'b1;
                case (cur_mode)
                    ppmd_pkg::MODE_PWM: begin
                        primary_next[slot_reg] = 1'b0;
                    end
                    ppmd_pkg::MODE_SWITCH: begin
                        primary_next[slot_reg] = above;
                    end
                    ppmd_pkg::MODE_INV_SWITCH: begin
                        primary_next[slot_reg] = below;
                    end
                    ppmd_pkg::MODE_SELECTOR: begin
                        secondary_next[slot_reg] = above;
                        primary_next[slot_reg]   = !above;
                    end
                    default: begin
                    end
                endcase
                // Either the frame ends or the next slot opens.
                if (slot_reg == LAST_SLOT) begin
                    slot_next     = '0;
                    in_frame_next = 1'b0;
                end else begin
                    slot_next = next_slot;
                    if (next_mode == ppmd_pkg::MODE_PWM) begin
                        primary_next[next_slot] = 1'b1;
                    end
                end
            end else if (edge_seen_reg &&
                         (gap > {{(ppmd_pkg::TIME_W-ppmd_pkg::WIDTH_W){1'b0}}, sync_gap_reg})) begin
                // A long enough gap is the sync pulse: slot 0 opens.
                in_frame_next = 1'b1;
                slot_next     = '0;
                if (first_mode == ppmd_pkg::MODE_PWM) begin
                    primary_next[0] = 1'b1;
                end
            end
            prev_time_next = item_time;
            edge_seen_next = 1'b1;
        end

        result.primary_pins   = primary_next;
        result.secondary_pins = secondary_next;
        result.frame_active   = in_frame_next;

        // Register writes; a new mode word parks the outputs of used channels.
        if (cfg_write) begin
            case (cfg_index)
                ppmd_pkg::CFG_CHANNEL_MODES: begin
                    modes_next = cfg_wdata;
                    for (int c = 0; c < CHANNELS; c++) begin
                        new_mode = cfg_wdata[ppmd_pkg::MODE_W*c +: ppmd_pkg::MODE_W];
                        if (new_mode != ppmd_pkg::MODE_NONE) begin
                            primary_next[c] = 1'b0;
                        end
                        if (new_mode == ppmd_pkg::MODE_SELECTOR) begin
                            secondary_next[c] = 1'b0;
                        end
                    end
                end
                ppmd_pkg::CFG_SYNC_GAP: begin
                    sync_gap_next = cfg_wdata[ppmd_pkg::WIDTH_W-1:0];
                end
                ppmd_pkg::CFG_SWITCH_THRESHOLD: begin
                    threshold_next = cfg_wdata[ppmd_pkg::WIDTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg     <= '0;
            sync_gap_reg  <= ppmd_pkg::SYNC_GAP_RESET;
            threshold_reg <= ppmd_pkg::THRESHOLD_RESET;
            in_frame_reg  <= 1'b0;
            edge_seen_reg <= 1'b0;
            slot_reg      <= '0;
            prev_time_reg <= '0;
            primary_reg   <= '0;
            secondary_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                width_store_reg[c] <= '0;
            end
        end else begin
            modes_reg       <= modes_next;
            sync_gap_reg    <= sync_gap_next;
            threshold_reg   <= threshold_next;
            in_frame_reg    <= in_frame_next;
            edge_seen_reg   <= edge_seen_next;
            slot_reg        <= slot_next;
            prev_time_reg   <= prev_time_next;
            primary_reg     <= primary_next;
            secondary_reg   <= secondary_next;
            width_store_reg <= width_store_next;
        end
    end

endmodule

// File: hw/rtl/ppmd_out_stage.sv
module ppmd_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  ppmd_pkg::ppmd_result_t             result,
    output logic                               load_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ppmd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    ppmd_pkg::ppmd_result_t out_data_reg;

    // The register can be refilled in the cycle its content is taken.
    assign load_ready = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;

    // Pack the result fields from the lowest bit up.
    assign m_tdata = {4'b0000,
                      out_data_reg.frame_active,
                      out_data_reg.channel_width_us,
                      out_data_reg.closed_channel,
                      out_data_reg.secondary_pins,
                      out_data_reg.primary_pins};
    assign m_tuser = out_data_reg.width_valid;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= result;
        end
    end

endmodule

// File: hw/rtl/ppm_frame_decoder_outputs.sv
// PPM frame decoder with one output pair per channel.
// The s_ channel takes one request per rising edge of the PPM train: s_tdata
// carries the free-running microsecond timestamp of that edge. For every edge
// the m_ channel returns one request with the current output pins and, when
// the edge closed a channel slot, that slot's index and measured width.
// The cfg_ channel writes the mode word, the sync gap and the switch
// threshold; it is always ready and is meant to be used while no edge is in
// flight.
// An accepted edge passes from the input register to the result register,
// which raises m_tvalid: the input register holds the edge while the slot
// logic feeds the result register. One edge is accepted every cycle while
// the receiver keeps m_tready high; the rate is set by the single update of
// the slot state.
// Reset clears the frame state, the stored widths and all pins, and loads the
// register defaults. When the receiver stalls, the result register holds its
// request, the input register takes one more edge, and s_tready then falls
// until m_tready returns.
module ppm_frame_decoder_outputs #(
    parameter int CHANNELS = ppmd_pkg::CHANNELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] edge_time_us
    input  logic [ppmd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] primary_pins, [15:8] secondary_pins, [18:16] closed_channel,
    // [34:19] channel_width_us, [35] frame_active, [39:36] zero
    output logic [ppmd_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] width_valid
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppmd_pkg::MODES_W-1:0]      cfg_wdata
);

`include "assert_macros.svh"

    logic                          down_ready;
    logic                          item_valid;
    logic                          item_advance;
    logic [ppmd_pkg::TIME_W-1:0]   item_time;
    ppmd_pkg::ppmd_result_t        result;

    // Register writes are taken at once.
    assign cfg_ready = 1'b1;

    // Input register.
    ppmd_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .down_ready   (down_ready),
        .item_valid   (item_valid),
        .item_advance (item_advance),
        .item_time    (item_time)
    );

    // Slot decoding, configuration and pin state.
    ppmd_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_advance (item_advance),
        .item_time    (item_time),
        .result       (result)
    );

    // Result register.
    ppmd_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (item_advance),
        .result     (result),
        .load_ready (down_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // An edge that leaves the input register always lands in the result register.
    `PPMD_ASSERT_NEXT(a_advance_fills_out, item_advance, m_tvalid)
    // A held edge is never blocked while the result register is empty.
    `PPMD_ASSERT_NOW(a_no_idle_stall, item_valid && !m_tvalid, item_advance)
    // Without a closed slot the index and width read as zero.
    `PPMD_ASSERT_NOW(a_unclosed_zero, m_tvalid && !m_tuser,
                     (m_tdata[18:16] == 3'd0) && (m_tdata[34:19] == 16'd0))

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmd_pkg::*;

    localparam int CHANNELS    = CHANNELS_DEFAULT;
    localparam int EDGE_TARGET = 620;
    localparam int CALM_EDGES  = 100;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    // The block ignores a write to the spare register index.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Mode codes like none on an edge, but a mode write drops their primary pin.
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // One channel in each mode, the spare codes on the top three channels.
    localparam logic [MODES_W-1:0] MODES_MIXED = {MODE_SPARE_7, MODE_SPARE_6, MODE_SPARE_5,
        MODE_NONE, MODE_SELECTOR, MODE_INV_SWITCH, MODE_SWITCH, MODE_PWM};

    typedef enum logic {ROW_EDGE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         index;
        logic [31:0]        value;
        bit                 typed;
        ppmd_result_t       result;
    } stim_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [MODES_W-1:0]     cfg_wdata = '0;

    // Decoder state as the testbench sees it.
    logic                   dec_in_frame = 1'b0;
    logic [SLOT_W-1:0]      dec_slot     = '0;
    logic [TIME_W-1:0]      dec_last_us  = '0;
    logic [WIDTH_W-1:0]     dec_widths [MAX_CHANNELS];
    logic [PIN_W-1:0]       dec_primary   = '0;
    logic [PIN_W-1:0]       dec_secondary = '0;
    logic                   dec_seen      = 1'b0;
    logic [MODES_W-1:0]     set_modes     = '0;
    logic [WIDTH_W-1:0]     set_sync_gap  = SYNC_GAP_RESET;
    logic [WIDTH_W-1:0]     set_threshold = THRESHOLD_RESET;

    ppmd_result_t           pending_decodes [$];
    stim_row_t              script [$];
    int                     edges_sent  = 0;
    int                     mismatches  = 0;
    int                     quiet_cycles = 0;
    int                     gap_odds    = 3;
    bit                     calm        = 1'b0;

    ppm_frame_decoder_outputs #(
        .CHANNELS(CHANNELS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            dec_widths[ch] = '0;
        end
    end

    // A channel in PWM mode raises its primary pin as its slot opens.
    function automatic void open_slot(int ch);
        if (set_modes[3*ch +: MODE_W] == MODE_PWM) begin
            dec_primary[ch] = 1'b1;
        end
    endfunction

    // Works out the decoded outputs for one edge and advances the frame state.
    function automatic ppmd_result_t decode_edge(logic [TIME_W-1:0] now);
        ppmd_result_t       res;
        int                 ch;
        logic [TIME_W-1:0]  span;
        logic               above;
        res = '0;
        if (dec_in_frame) begin
            ch = dec_slot;
            if (now > dec_last_us) begin
                span = now - dec_last_us;
                dec_widths[ch] = (span > 32'h0000_FFFF) ? 16'hFFFF : span[WIDTH_W-1:0];
            end
            res.channel_width_us = dec_widths[ch];
            res.closed_channel   = dec_slot;
            res.width_valid      = 1'b1;
            above = dec_widths[ch] > set_threshold;
            case (set_modes[3*ch +: MODE_W])
                MODE_PWM: begin
                    dec_primary[ch] = 1'b0;
                end
                MODE_SWITCH: begin
                    dec_primary[ch] = above;
                end
                MODE_INV_SWITCH: begin
                    dec_primary[ch] = dec_widths[ch] < set_threshold;
                end
                MODE_SELECTOR: begin
                    dec_secondary[ch] = above;
                    dec_primary[ch]   = !above;
                end
                default: begin
                end
            endcase
            if (ch == CHANNELS - 1) begin
                dec_slot     = '0;
                dec_in_frame = 1'b0;
            end else begin
                dec_slot = SLOT_W'(ch + 1);
                open_slot(ch + 1);
            end
        end else if (dec_seen && (now - dec_last_us) > set_sync_gap) begin
            dec_slot     = '0;
            dec_in_frame = 1'b1;
            open_slot(0);
        end
        dec_last_us = now;
        dec_seen    = 1'b1;
        res.primary_pins   = dec_primary;
        res.secondary_pins = dec_secondary;
        res.frame_active   = dec_in_frame;
        return res;
    endfunction

    // Register writes as the block applies them; nonzero modes drop primary pins.
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [MODES_W-1:0] data);
        case (idx)
            CFG_CHANNEL_MODES: begin
                set_modes = data;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (set_modes[3*ch +: MODE_W] != MODE_NONE) begin
                        dec_primary[ch] = 1'b0;
                        if (set_modes[3*ch +: MODE_W] == MODE_SELECTOR) begin
                            dec_secondary[ch] = 1'b0;
                        end
                    end
                end
            end
            CFG_SYNC_GAP: begin
                set_sync_gap = data[WIDTH_W-1:0];
            end
            CFG_SWITCH_THRESHOLD: begin
                set_threshold = data[WIDTH_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int field_check(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    // Time from one edge to the next inside a frame, mostly servo-like widths.
    function automatic logic [TIME_W-1:0] slot_step();
        logic [TIME_W-1:0] thr;
        thr = TIME_W'(set_threshold);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 32'd0 - $urandom_range(1, 5000);
            2:       return $urandom_range(65536, 1000000);
            3:       return thr;
            4:       return thr + 1;
            5:       return thr - 1;
            6:       return $urandom;
            default: return $urandom_range(900, 2100);
        endcase
    endfunction

    function automatic void add_edge(logic [TIME_W-1:0] t);
        stim_row_t row;
        row.kind   = ROW_EDGE;
        row.index  = '0;
        row.value  = t;
        row.typed  = 1'b0;
        row.result = '0;
        script.push_back(row);
    endfunction

    function automatic void add_typed_edge(logic [TIME_W-1:0] t, ppmd_result_t res);
        stim_row_t row;
        row.kind   = ROW_EDGE;
        row.index  = '0;
        row.value  = t;
        row.typed  = 1'b1;
        row.result = res;
        script.push_back(row);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [MODES_W-1:0] data);
        stim_row_t row;
        row.kind   = ROW_WRITE;
        row.index  = idx;
        row.value  = 32'(data);
        row.typed  = 1'b0;
        row.result = '0;
        script.push_back(row);
    endfunction

    // Holds the sender back until every outstanding result has come out. With
    // nothing outstanding the valid is already low, so it is left alone.
    task automatic drain();
        if (pending_decodes.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_decodes.size() != 0) begin
                @(posedge aclk);
            end
        end
    endtask

    // Sends one edge request; a typed result replaces the predicted one.
    task automatic send_edge(logic [TIME_W-1:0] t, bit typed, ppmd_result_t res);
        ppmd_result_t predicted;
        cfg_valid <= 1'b0;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = decode_edge(t);
        pending_decodes.push_back(typed ? res : predicted);
        edges_sent++;
    endtask

    // Register writes happen only with nothing in flight. The valid stays up
    // until the next edge request so back-to-back writes need no bubble.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [MODES_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        apply_register(idx, data);
    endtask

    // New settings, then eight frames with a little noise between them.
    task automatic random_phase();
        logic [MODES_W-1:0] modes;
        logic [WIDTH_W-1:0] value16;
        logic [TIME_W-1:0]  clock_us;
        logic [7:0]         junk;
        int                 quiet_at;
        case ($urandom_range(0, 4))
            0: modes = '0;
            1: modes = '1;
            2: modes = MODES_W'($urandom);
            default: begin
                for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                    modes[3*ch +: MODE_W] = MODE_W'($urandom_range(MODE_NONE, MODE_SELECTOR));
                end
            end
        endcase
        write_register(CFG_CHANNEL_MODES, modes);
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
                0: value16 = '0;
                1: value16 = '1;
                default: value16 = WIDTH_W'($urandom_range(2000, 5000));
            endcase
            junk = 8'($urandom);
            write_register(CFG_SYNC_GAP, {junk, value16});
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
                0: value16 = '0;
                1: value16 = '1;
                default: value16 = WIDTH_W'($urandom_range(800, 2200));
            endcase
            junk = 8'($urandom);
            write_register(CFG_SWITCH_THRESHOLD, {junk, value16});
        end
        if ($urandom_range(0, 5) == 0) begin
            write_register(CFG_UNMAPPED, MODES_W'($urandom));
        end

        gap_odds = $urandom_range(0, 6);
        clock_us = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                               : $urandom;
        quiet_at = $urandom_range(0, 7);
        for (int frame = 0; frame < 8; frame++) begin
            if (frame == quiet_at) begin
                drain();
            end
            // Stray edges between frames.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    clock_us = ($urandom_range(0, 1) == 0) ? $urandom
                                                           : clock_us + $urandom_range(0, 3000);
                    send_edge(clock_us, 1'b0, '0);
                end
            end
            // Sync gap, now and then exactly at the threshold so no frame opens.
            clock_us = clock_us + set_sync_gap
                     + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4000));
            send_edge(clock_us, 1'b0, '0);
            for (int slot = 0; slot < CHANNELS; slot++) begin
                clock_us = clock_us + slot_step();
                send_edge(clock_us, 1'b0, '0);
            end
        end
    endtask

    // Receiver: ready stretches broken by stalls, none once the run is calm.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // Each result request is compared with the oldest outstanding decode.
    always @(posedge aclk) begin : result_check
        ppmd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t ns: result expected none, got 0x%0h (user %0b)",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_decodes.pop_front();
                mismatches += field_check("primary_pins", want.primary_pins, m_tdata[7:0]);
                mismatches += field_check("secondary_pins", want.secondary_pins,
                                          m_tdata[15:8]);
                mismatches += field_check("closed_channel", want.closed_channel,
                                          m_tdata[18:16]);
                mismatches += field_check("channel_width_us", want.channel_width_us,
                                          m_tdata[34:19]);
                mismatches += field_check("frame_active", want.frame_active, m_tdata[35]);
                mismatches += field_check("padding", '0, m_tdata[39:36]);
                mismatches += field_check("width_valid", want.width_valid, m_tuser);
            end
        end
    end

    // Watchdog: too long without any request moving on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("** ppm_frame_decoder_outputs: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        ppmd_result_t blank;
        ppmd_result_t opened;
        stim_row_t    row;
        blank  = '0;
        opened = '0;
        opened.primary_pins = 8'h01;
        opened.frame_active = 1'b1;

        // One channel per mode; a write to the spare index must change nothing.
        add_write(CFG_CHANNEL_MODES, MODES_MIXED);
        add_write(CFG_UNMAPPED, '1);
        // The first edge after reset never opens a frame, whatever the gap.
        add_typed_edge(32'hFFFF_FFFF, blank);
        // The gap across the timestamp wrap is 3001, so the frame opens and
        // the PWM channel goes high.
        add_typed_edge(32'd3000, opened);
        add_edge(32'd4000);
        add_edge(32'd5501);
        add_edge(32'd7001);
        // Time standing still, then running backwards: old widths are reused.
        add_edge(32'd7001);
        add_edge(32'd6000);
        // A slot far too long saturates.
        add_edge(32'd76001);
        add_edge(32'd76002);
        add_edge(32'd76003);
        // A gap of exactly the threshold does not open a frame.
        add_edge(32'd79003);
        // Spare codes everywhere, zero gap, top threshold; upper data bits ignored.
        add_write(CFG_CHANNEL_MODES, {8{MODE_SPARE_7}});
        add_write(CFG_SYNC_GAP, 24'hAB0000);
        add_write(CFG_SWITCH_THRESHOLD, 24'hFFFFFF);
        add_edge(32'd79004);
        add_edge(32'd144539);
        // Selector everywhere, written in the middle of a frame.
        add_write(CFG_CHANNEL_MODES, {8{MODE_SELECTOR}});
        add_edge(32'd210075);
        add_edge(32'd0);
        add_edge(32'd0);
        add_edge(32'hFFFF_FFFF);
        add_edge(32'h0000_FFFE);
        add_write(CFG_SWITCH_THRESHOLD, '0);
        add_edge(32'h0000_FFFF);
        add_edge(32'h0001_0000);
        add_write(CFG_SYNC_GAP, 24'(SYNC_GAP_RESET));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_WRITE) begin
                write_register(row.index, row.value[MODES_W-1:0]);
            end else begin
                send_edge(row.value, row.typed, row.result);
            end
        end

        while (edges_sent < EDGE_TARGET) begin
            if (edges_sent >= EDGE_TARGET - CALM_EDGES) begin
                calm = 1'b1;
            end
            random_phase();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_decodes.size() == 0) begin
            $display("** ppm_frame_decoder_outputs: PASSED **");
        end else begin
            $display("** ppm_frame_decoder_outputs: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ppmd_pkg.sv
hw/rtl/ppmd_in_stage.sv
hw/rtl/ppmd_core.sv
hw/rtl/ppmd_out_stage.sv
hw/rtl/ppm_frame_decoder_outputs.sv
verif/tb.sv
